/* hdl/msdrs_pkg.sv */
// Package for the multi-slot DRAM read streamer.
// Holds sizes, payload structs and the controller command struct; no dependencies.
package msdrs_pkg;

	localparam int SLOTS     = 4;
	localparam int ADDR_BITS = 32;
	localparam int LEN_BITS  = 16;
	localparam int TAG_W     = 8;
	localparam int STEP_W    = 8;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 2);
	localparam int WIDE_W = ADDR_BITS + 1;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64);

	typedef struct packed {
		logic                 new_valid;
		logic [ADDR_BITS-1:0] new_base;
		logic [LEN_BITS-1:0]  new_length;
		logic                 new_inhibitory;
		logic                 new_has_target;
	} in_item_t;

	typedef struct packed {
		logic                 accepted;
		logic                 req_valid;
		logic [ADDR_BITS-1:0] req_address;
		logic [TAG_W-1:0]     req_tag;
		logic [LEN_BITS-1:0]  req_length;
		logic                 req_inhibitory;
		logic                 req_offset_flag;
		logic                 idle_valid;
		logic                 idle_value;
		logic                 length_error;
	} result_t;

	typedef struct packed {
		logic latch;
		logic admit;
		logic pick;
		logic serve;
	} ctrl_cmd_t;

endpackage

/* hdl/msdrs_ctrl.sv */
// Controller of the read streamer: sequences latch, admission, job pick and service.
// Depends on msdrs_pkg for the command struct.
module msdrs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output msdrs_pkg::ctrl_cmd_t  cmd
);
	import msdrs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ADMIT = 4'b0010,
		S_PICK  = 4'b0100,
		S_SERVE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (start) state_d = S_ADMIT;
			S_ADMIT: state_d = S_PICK;
			S_PICK:  state_d = S_SERVE;
			S_SERVE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign cmd.latch = (state_q == S_IDLE) && start;
	assign cmd.admit = (state_q == S_ADMIT);
	assign cmd.pick  = (state_q == S_PICK);
	assign cmd.serve = (state_q == S_SERVE);

endmodule

/* hdl/msdrs_datapath.sv */
// Datapath of the read streamer: slot registers, free FIFO, work list, round-robin
// pointer, step register and the result register. Depends on msdrs_pkg.
module msdrs_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  msdrs_pkg::ctrl_cmd_t          cmd,
	input  msdrs_pkg::in_item_t           item,
	input  logic                          cfg_we,
	input  logic [msdrs_pkg::STEP_W-1:0]  cfg_data,
	output logic                          result_valid,
	output msdrs_pkg::result_t            result
);
	import msdrs_pkg::*;

	// Per-slot job registers.
	logic [ADDR_BITS-1:0] slot_base_q   [SLOTS];
	logic [LEN_BITS-1:0]  slot_len_q    [SLOTS];
	logic [WIDE_W-1:0]    slot_ra_q     [SLOTS];
	logic [TAG_W-1:0]     slot_tag_q    [SLOTS];
	logic [1:0]           slot_flags_q  [SLOTS];
	logic [TAG_W-1:0]     next_tag_q    [SLOTS];

	logic [SLOT_W-1:0]    free_fifo_q   [SLOTS];
	logic [SLOT_W-1:0]    work_q        [SLOTS];
	logic [CNT_W-1:0]     free_cnt_q;
	logic [CNT_W-1:0]     work_cnt_q;
	logic [CNT_W-1:0]     rr_q;
	logic [CNT_W-1:0]     ongoing_q;
	logic [STEP_W-1:0]    step_q;

	in_item_t             item_q;
	logic                 acc_q;
	logic                 err_q;
	logic                 idle_v_q;
	logic                 idle_val_q;

	logic                 pick_empty_q;
	logic [SLOT_W-1:0]    pick_m_q;
	logic [SLOT_W-1:0]    pick_s_q;
	logic [ADDR_BITS-1:0] pick_base_q;
	logic [LEN_BITS-1:0]  pick_len_q;
	logic [WIDE_W-1:0]    pick_ra_q;
	logic [WIDE_W-1:0]    pick_end_q;
	logic [TAG_W-1:0]     pick_tag_q;
	logic [1:0]           pick_flags_q;

	result_t              result_q;
	logic                 result_valid_q;
	result_t              res_d;

	logic                 take;
	logic [SLOT_W-1:0]    new_slot;
	logic [CNT_W-1:0]     rr_r1;
	logic [CNT_W-1:0]     rr_red;
	logic [SLOT_W-1:0]    sel_m;
	logic [SLOT_W-1:0]    sel_s;
	logic                 in_range;
	logic                 first_read;
	logic                 retire;

	assign take     = item_q.new_valid && (free_cnt_q != '0);
	assign new_slot = free_fifo_q[0];

	// The pointer never runs more than one past the list length, so two
	// conditional subtractions finish the reduction.
	always_comb begin
		rr_r1  = (rr_q >= work_cnt_q) ? (rr_q - work_cnt_q) : rr_q;
		rr_red = (rr_r1 >= work_cnt_q) ? (rr_r1 - work_cnt_q) : rr_r1;
		sel_m  = rr_red[SLOT_W-1:0];
		sel_s  = work_q[sel_m];
	end

	assign in_range   = !pick_empty_q && (pick_ra_q < pick_end_q) &&
	                    (pick_ra_q >= {1'b0, pick_base_q});
	assign first_read = (pick_ra_q == {1'b0, pick_base_q});
	assign retire     = cmd.serve && !pick_empty_q && !in_range;

	always_comb begin
		res_d              = '0;
		res_d.accepted     = acc_q;
		res_d.length_error = err_q;
		res_d.idle_valid   = idle_v_q;
		res_d.idle_value   = idle_val_q;
		if (pick_empty_q) begin
			res_d.idle_valid = 1'b1;
			res_d.idle_value = 1'b1;
		end else if (in_range) begin
			res_d.req_valid      = 1'b1;
			res_d.req_address    = pick_ra_q[ADDR_BITS-1:0];
			res_d.req_tag        = pick_tag_q;
			res_d.req_inhibitory = pick_flags_q[0];
			if (first_read) begin
				res_d.req_length      = pick_len_q;
				res_d.req_offset_flag = pick_flags_q[1];
			end
		end else if (ongoing_q == '0) begin
			res_d.idle_valid = 1'b1;
			res_d.idle_value = 1'b1;
		end
	end

	// Input latch, pick registers and slot payloads carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
		if (cmd.admit && take) begin
			slot_base_q[new_slot]  <= item_q.new_base;
			slot_len_q[new_slot]   <= item_q.new_length;
			slot_ra_q[new_slot]    <= {1'b0, item_q.new_base};
			slot_tag_q[new_slot]   <= next_tag_q[new_slot];
			slot_flags_q[new_slot] <= {item_q.new_has_target, item_q.new_inhibitory};
		end
		if (cmd.serve && in_range) begin
			slot_ra_q[pick_s_q] <= pick_ra_q + {{(WIDE_W-STEP_W){1'b0}}, step_q};
		end
		if (cmd.pick) begin
			pick_m_q     <= sel_m;
			pick_s_q     <= sel_s;
			pick_base_q  <= slot_base_q[sel_s];
			pick_len_q   <= slot_len_q[sel_s];
			pick_ra_q    <= slot_ra_q[sel_s];
			pick_end_q   <= {1'b0, slot_base_q[sel_s]} +
			                {{(WIDE_W-LEN_BITS){1'b0}}, slot_len_q[sel_s]};
			pick_tag_q   <= slot_tag_q[sel_s];
			pick_flags_q <= slot_flags_q[sel_s];
		end
		if (cmd.serve) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				next_tag_q[i]  <= TAG_W'(i);
				free_fifo_q[i] <= SLOT_W'(i);
				work_q[i]      <= '0;
			end
			free_cnt_q     <= CNT_W'(SLOTS);
			work_cnt_q     <= '0;
			rr_q           <= '0;
			ongoing_q      <= '0;
			step_q         <= STEP_RESET;
			acc_q          <= 1'b0;
			err_q          <= 1'b0;
			idle_v_q       <= 1'b0;
			idle_val_q     <= 1'b0;
			pick_empty_q   <= 1'b1;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.serve;
			if (cfg_we) begin
				step_q <= cfg_data;
			end
			if (cmd.admit) begin
				acc_q      <= take;
				err_q      <= take && (item_q.new_length == '0);
				idle_v_q   <= take && (ongoing_q == '0);
				idle_val_q <= 1'b0;
				if (take) begin
					for (int i = 0; i < SLOTS - 1; i++) begin
						free_fifo_q[i] <= free_fifo_q[i+1];
					end
					free_cnt_q                         <= free_cnt_q - CNT_W'(1);
					work_q[work_cnt_q[SLOT_W-1:0]]     <= new_slot;
					work_cnt_q                         <= work_cnt_q + CNT_W'(1);
					ongoing_q                          <= ongoing_q + CNT_W'(1);
					next_tag_q[new_slot]               <= next_tag_q[new_slot] + TAG_W'(SLOTS);
				end
			end
			if (cmd.pick) begin
				pick_empty_q <= (work_cnt_q == '0);
			end
			if (cmd.serve && !pick_empty_q) begin
				rr_q <= {{(CNT_W-SLOT_W){1'b0}}, pick_m_q} + CNT_W'(1);
			end
			if (retire) begin
				if (ongoing_q != '0) begin
					ongoing_q <= ongoing_q - CNT_W'(1);
				end
				free_fifo_q[free_cnt_q[SLOT_W-1:0]] <= pick_s_q;
				free_cnt_q                          <= free_cnt_q + CNT_W'(1);
				for (int i = 0; i < SLOTS - 1; i++) begin
					if (i >= int'(pick_m_q)) begin
						work_q[i] <= work_q[i+1];
					end
				end
				work_cnt_q <= work_cnt_q - CNT_W'(1);
			end
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

/* hdl/multi_slot_dram_read_streamer_core.sv */
// Top level of the multi-slot DRAM read streamer.
// Joins msdrs_ctrl and msdrs_datapath; depends on msdrs_pkg.
//
// Each tick is one transaction on start/busy: start is latched in the idle state,
// then the controller steps through admission, job pick and service, busy being
// high from admission through service. The tick's result is loaded into an output
// register and shown for exactly one cycle with result_valid high, registered from
// the serve state; the receiver cannot stall it, so it must take every result in
// that cycle. The step register is written through cfg_valid/cfg_data, always ready;
// the user must write it only while the block is idle; the block does not enforce it.
module multi_slot_dram_read_streamer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  msdrs_pkg::in_item_t           item,
	output logic                          result_valid,
	output msdrs_pkg::result_t            result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [msdrs_pkg::STEP_W-1:0]  cfg_data
);
	import msdrs_pkg::*;

	ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	msdrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	msdrs_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

/* bench/tb_multi_slot_dram_read_streamer_core.sv */
// Self-checking bench for multi_slot_dram_read_streamer_core: a table of directed ticks,
// then phases of random ticks at several read steps, checked against a local slot model.
// Depends on msdrs_pkg and the RTL top level only.
module tb_multi_slot_dram_read_streamer_core;
	import msdrs_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASES      = 5;
	localparam int PHASE_TICKS = 80;

	typedef struct packed {
		in_item_t stim;
		logic     typed;
		result_t  res;
	} tick_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	in_item_t          item;
	logic              result_valid;
	result_t           result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [STEP_W-1:0] cfg_data;

	// Slot model: per-slot job registers, free slot FIFO and ordered work list.
	logic [ADDR_BITS-1:0] job_base   [SLOTS];
	logic [LEN_BITS-1:0]  job_len    [SLOTS];
	logic [WIDE_W-1:0]    job_cursor [SLOTS];
	logic [TAG_W-1:0]     job_tag    [SLOTS];
	logic                 job_inh    [SLOTS];
	logic                 job_tgt    [SLOTS];
	logic [TAG_W-1:0]     tag_next   [SLOTS];
	int                   free_slots[$];
	int                   job_order[$];
	int                   rr_ptr;
	int                   open_jobs;
	logic [STEP_W-1:0]    cur_step;

	result_t   tick_results_due[$];
	tick_row_t script[$];

	int mismatches    = 0;
	int cycle_count   = 0;
	int ticks_sent    = 0;
	int n_admitted    = 0;
	int n_refused     = 0;
	int n_zero_len    = 0;
	int n_reads       = 0;
	int n_retired     = 0;
	int step_settings = 0;

	multi_slot_dram_read_streamer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// One tick of the streamer: admission first, then one round-robin turn.
	function automatic result_t streamer_tick(input in_item_t it);
		result_t           r;
		int                s;
		logic [WIDE_W-1:0] ra;
		logic [WIDE_W-1:0] lo;
		logic [WIDE_W-1:0] hi;
		r = '0;
		if (it.new_valid) begin
			if (free_slots.size() > 0) begin
				s = free_slots[0];
				free_slots.delete(0);
				job_order.insert(job_order.size(), s);
				job_base[s]   = it.new_base;
				job_len[s]    = it.new_length;
				job_cursor[s] = {1'b0, it.new_base};
				job_tag[s]    = tag_next[s];
				job_inh[s]    = it.new_inhibitory;
				job_tgt[s]    = it.new_has_target;
				tag_next[s]   = tag_next[s] + TAG_W'(SLOTS);
				r.accepted = 1'b1;
				if (open_jobs == 0) begin
					r.idle_valid = 1'b1;
					r.idle_value = 1'b0;
				end
				open_jobs++;
				n_admitted++;
				if (it.new_length == '0) begin
					r.length_error = 1'b1;
					n_zero_len++;
				end
			end else begin
				n_refused++;
			end
		end
		if (job_order.size() == 0) begin
			r.idle_valid = 1'b1;
			r.idle_value = 1'b1;
		end else begin
			rr_ptr = rr_ptr % job_order.size();
			s  = job_order[rr_ptr];
			ra = job_cursor[s];
			lo = {1'b0, job_base[s]};
			hi = lo + WIDE_W'(job_len[s]);
			if (ra < hi && ra >= lo) begin
				r.req_valid      = 1'b1;
				r.req_address    = ra[ADDR_BITS-1:0];
				r.req_tag        = job_tag[s];
				r.req_inhibitory = job_inh[s];
				if (ra == lo) begin
					r.req_length      = job_len[s];
					r.req_offset_flag = job_tgt[s];
				end
				job_cursor[s] = ra + WIDE_W'(cur_step);
				n_reads++;
			end else begin
				if (open_jobs != 0) begin
					open_jobs--;
				end else begin
					r.idle_valid = 1'b1;
					r.idle_value = 1'b1;
				end
				if (free_slots.size() < SLOTS)
					free_slots.insert(free_slots.size(), s);
				job_order.delete(rr_ptr);
				n_retired++;
			end
			rr_ptr++;
		end
		return r;
	endfunction

	function automatic result_t outcome(input bit acc, input bit rv, input logic [31:0] addr,
			input logic [7:0] tg, input logic [15:0] ln, input bit inh, input bit off,
			input bit iv, input bit ival, input bit lerr);
		result_t r;
		r.accepted        = acc;
		r.req_valid       = rv;
		r.req_address     = addr;
		r.req_tag         = tg;
		r.req_length      = ln;
		r.req_inhibitory  = inh;
		r.req_offset_flag = off;
		r.idle_valid      = iv;
		r.idle_value      = ival;
		r.length_error    = lerr;
		return r;
	endfunction

	function automatic void add_row(input bit v, input logic [31:0] base, input logic [15:0] len,
			input bit inh, input bit tgt, input bit typed, input result_t res);
		tick_row_t row;
		row.stim.new_valid      = v;
		row.stim.new_base       = base;
		row.stim.new_length     = len;
		row.stim.new_inhibitory = inh;
		row.stim.new_has_target = tgt;
		row.typed               = typed;
		row.res                 = res;
		script.insert(script.size(), row);
	endfunction

	function automatic in_item_t random_request(input logic [STEP_W-1:0] stp);
		in_item_t it;
		int       pick;
		pick = $urandom_range(0, 31);
		it.new_valid = ($urandom_range(0, 9) < 6);
		it.new_base  = $urandom;
		if ($urandom_range(0, 7) == 0)
			it.new_base = 32'hFFFF_FFFF - $urandom_range(0, 1023);
		// Stream lengths scale with the step: at most six steps, or 24 below a step of 4.
		if (pick < 2)
			it.new_length = '0;
		else
			it.new_length = LEN_BITS'($urandom_range(1, (stp < 4) ? 24 : stp * 6));
		it.new_inhibitory = 1'($urandom_range(0, 1));
		it.new_has_target = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic run_tick(input in_item_t it, input int gap_pct, input bit typed,
			input result_t typed_res);
		result_t predicted;
		@(negedge clk);
		if ($urandom_range(0, 99) < gap_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		start = 1'b1;
		item  = it;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = streamer_tick(it);
		tick_results_due.insert(tick_results_due.size(), typed ? typed_res : predicted);
		ticks_sent++;
	endtask

	task automatic park();
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic set_step(input logic [STEP_W-1:0] stp);
		park();
		while (tick_results_due.size() != 0 || busy !== 1'b0) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = stp;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cur_step = stp;
		step_settings++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && result_valid === 1'b1) begin
			if (tick_results_due.size() == 0) begin
				$error("result with no tick outstanding: %h", result);
				mismatches++;
			end else begin
				want = tick_results_due[0];
				tick_results_due.delete(0);
				check_field("accepted", 64'(want.accepted), 64'(result.accepted));
				check_field("req_valid", 64'(want.req_valid), 64'(result.req_valid));
				check_field("req_address", 64'(want.req_address), 64'(result.req_address));
				check_field("req_tag", 64'(want.req_tag), 64'(result.req_tag));
				check_field("req_length", 64'(want.req_length), 64'(result.req_length));
				check_field("req_inhibitory", 64'(want.req_inhibitory),
					64'(result.req_inhibitory));
				check_field("req_offset_flag", 64'(want.req_offset_flag),
					64'(result.req_offset_flag));
				check_field("idle_valid", 64'(want.idle_valid), 64'(result.idle_valid));
				check_field("idle_value", 64'(want.idle_value), 64'(result.idle_value));
				check_field("length_error", 64'(want.length_error),
					64'(result.length_error));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_multi_slot_dram_read_streamer_core: done, errors");
			$finish;
		end
	end

	initial begin
		int          p;
		int          n;
		logic [7:0]  stp;
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		for (p = 0; p < SLOTS; p++) begin
			tag_next[p] = TAG_W'(p);
			free_slots.insert(free_slots.size(), p);
		end
		rr_ptr    = 0;
		open_jobs = 0;
		cur_step  = STEP_RESET;

		// Empty tick after reset, then a zero-length job that retires on its first turn.
		add_row(1'b0, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 1'b1,
			outcome(1'b0, 1'b0, 32'h0, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
		add_row(1'b1, 32'h0000_1000, 16'h0000, 1'b1, 1'b1, 1'b1,
			outcome(1'b1, 1'b0, 32'h0, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
		// Top of the address space with the longest stream: its cursor goes past 32 bits.
		add_row(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1,
			outcome(1'b1, 1'b1, 32'hFFFF_FFFF, 8'h01, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0,
				1'b0));
		add_row(1'b1, 32'h0000_0000, 16'h0001, 1'b1, 1'b0, 1'b0, '0);
		add_row(1'b1, 32'hFFFF_FFC0, 16'h0080, 1'b1, 1'b1, 1'b0, '0);
		add_row(1'b1, 32'h8000_0000, 16'h0100, 1'b0, 1'b0, 1'b0, '0);
		// All slots taken: these are refused.
		add_row(1'b1, 32'h5555_5555, 16'hAAAA, 1'b1, 1'b1, 1'b0, '0);
		add_row(1'b1, 32'hAAAA_AAAA, 16'h5555, 1'b0, 1'b0, 1'b0, '0);
		add_row(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, '0);
		add_row(1'b0, 32'h1234_5678, 16'h00C0, 1'b0, 1'b1, 1'b0, '0);
		add_row(1'b1, 32'h0000_0040, 16'h0000, 1'b0, 1'b1, 1'b0, '0);
		add_row(1'b1, 32'h7FFF_FFF0, 16'h0041, 1'b1, 1'b1, 1'b0, '0);
		add_row(1'b1, 32'h0001_0000, 16'h0180, 1'b0, 1'b1, 1'b0, '0);
		add_row(1'b0, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
		add_row(1'b1, 32'hFFFF_FF00, 16'h0100, 1'b1, 1'b0, 1'b0, '0);
		add_row(1'b0, 32'h0F0F_0F0F, 16'hF0F0, 1'b1, 1'b0, 1'b0, '0);
		add_row(1'b1, 32'h0000_0003, 16'h003F, 1'b0, 1'b0, 1'b0, '0);
		add_row(1'b0, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 1'b0, '0);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (script[i])
			run_tick(script[i].stim, 30, script[i].typed, script[i].res);

		// Jobs still open carry over into each new step setting.
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0:       stp = 8'd255;
				1:       stp = 8'd1;
				3:       stp = 8'd128;
				default: stp = STEP_W'($urandom_range(2, 254));
			endcase
			set_step(stp);
			// Idle bursts in the first half of each phase; none at all in the last phase.
			for (n = 0; n < PHASE_TICKS; n++)
				run_tick(random_request(cur_step), (p == PHASES - 1 || n >= 40) ? 0 : 30,
					1'b0, '0);
		end

		park();
		while (tick_results_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("%0d ticks over %0d step settings; %0d requests admitted, %0d refused, %0d empty",
			ticks_sent, step_settings, n_admitted, n_refused, n_zero_len);
		$display("%0d reads issued and %0d jobs retired", n_reads, n_retired);
		if (mismatches == 0)
			$display("tb_multi_slot_dram_read_streamer_core: done, clean");
		else
			$display("tb_multi_slot_dram_read_streamer_core: done, errors");
		$finish;
	end

endmodule
